/* rtl/skq_pkg.sv */
// ----------------------------------------------------------------------------
// skq_pkg
// Shared types and constants for the stable key sort queue.
// ----------------------------------------------------------------------------
package skq_pkg;

   // Fixed field widths of the channels.
   localparam int KEY_BITS         = 8;
   localparam int OUT_PAYLOAD_BITS = 32;
   // Widest stored payload; used to resize between port and store widths.
   localparam int WIDE_BITS        = 64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // write the accepted item into the store, or drop it if full
      logic start;      // begin the drain: rewind the scan, open the min-search pass
      logic eval;       // consume the entry read at the scan index
      logic advance;    // step the scan index to the next entry
      logic next_pass;  // close the pass and move to the next larger key
      logic finish;     // empty the store after the drain
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;        // the current entry holds the key being emitted
      logic out_free;   // the result register can take a transfer this cycle
      logic idx_last;   // the scan index is at the last stored entry
      logic found;      // a key for the next pass is left, counting the current entry
   } status_type;

endpackage

/* rtl/skq_if.sv */
// ----------------------------------------------------------------------------
// skq_req_if / skq_rsp_if
// Valid/ready channels for input items and sorted results.
// ----------------------------------------------------------------------------
interface skq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [skq_pkg::KEY_BITS-1:0]           item_key;
   logic [skq_pkg::OUT_PAYLOAD_BITS-1:0]   item_payload;
   logic                                   item_last;

   modport source (output valid, item_key, item_payload, item_last, input ready);
   modport sink   (input valid, item_key, item_payload, item_last, output ready);
endinterface

interface skq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [skq_pkg::KEY_BITS-1:0]           out_key;
   logic [skq_pkg::OUT_PAYLOAD_BITS-1:0]   out_payload;
   logic                                   out_last;
   logic                                   overflow_seen;

   modport source (output valid, out_key, out_payload, out_last, overflow_seen, input ready);
   modport sink   (input valid, out_key, out_payload, out_last, overflow_seen, output ready);
endinterface

/* rtl/stable_key_sort_queue_core.sv */
// Loading: one item is taken per cycle while the block is in its load phase.
// Drain: after an item marked last, the store of N items is walked once to
// find the smallest key, then once more per distinct key D; each entry is first
// read from the RAM and then compared, and the compare holds while a result waits.
// First result: when the second pass meets the first smallest-key entry.
// Reset is synchronous: it empties the store and clears the dropped flag.
// ----------------------------------------------------------------------------
// stable_key_sort_queue_core
// Stable ascending sort of a set of keyed items held in an on-chip store.
// ----------------------------------------------------------------------------
module stable_key_sort_queue_core #(
   parameter int CAPACITY     = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   skq_req_if.sink    req_chan,
   skq_rsp_if.source  rsp_chan
);

   skq_pkg::cmd_type    cmd;
   skq_pkg::status_type status;
   logic                req_ready;

   // Sequencer.
   skq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.item_last),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   assign req_chan.ready = req_ready;

   // Store, search registers and result register.
   skq_datapath #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_key      (req_chan.item_key),
      .req_payload  (req_chan.item_payload),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_key      (rsp_chan.out_key),
      .rsp_payload  (rsp_chan.out_payload),
      .rsp_last     (rsp_chan.out_last),
      .rsp_overflow (rsp_chan.overflow_seen)
   );

endmodule

/* rtl/skq_ram.sv */
// ----------------------------------------------------------------------------
// skq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/skq_ctrl.sv */
// ----------------------------------------------------------------------------
// skq_ctrl
// Sequencer: loads, then walks the store once, then once per distinct key.
// ----------------------------------------------------------------------------
module skq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   input  skq_pkg::status_type status,
   output skq_pkg::cmd_type    cmd,
   output logic                req_ready
);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_READ = 3'b010,
      ST_EVAL = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            // The store read issued at the scan index returns next cycle.
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // Hold while an entry to emit finds the result register occupied.
            if (!(status.hit && !status.out_free)) begin
               cmd.eval = 1'b1;
               if (status.idx_last) begin
                  if (status.found) begin
                     cmd.next_pass = 1'b1;
                     state_in      = ST_READ;
                  end else begin
                     cmd.finish = 1'b1;
                     state_in   = ST_LOAD;
                  end
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/skq_datapath.sv */
// ----------------------------------------------------------------------------
// skq_datapath
// Item store, scan index, key search registers and the result register.
// ----------------------------------------------------------------------------
module skq_datapath #(
   parameter int CAPACITY     = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  skq_pkg::cmd_type                      cmd,
   output skq_pkg::status_type                   status,
   input  logic [skq_pkg::KEY_BITS-1:0]          req_key,
   input  logic [skq_pkg::OUT_PAYLOAD_BITS-1:0]  req_payload,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [skq_pkg::KEY_BITS-1:0]          rsp_key,
   output logic [skq_pkg::OUT_PAYLOAD_BITS-1:0]  rsp_payload,
   output logic                                  rsp_last,
   output logic                                  rsp_overflow
);

   localparam int AddrBits  = $clog2(CAPACITY);
   localparam int CountBits = $clog2(CAPACITY + 1);
   localparam int KeyBits   = skq_pkg::KEY_BITS;
   localparam int OutBits   = skq_pkg::OUT_PAYLOAD_BITS;
   localparam int WideBits  = skq_pkg::WIDE_BITS;

   logic [CountBits-1:0]    count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic [AddrBits-1:0]     idx_ff, idx_in;
   logic [KeyBits-1:0]      cur_key_ff, cur_key_in;
   logic [KeyBits-1:0]      next_key_ff, next_key_in;
   logic                    next_found_ff, next_found_in;
   logic                    first_pass_ff, first_pass_in;
   logic [CountBits-1:0]    remain_ff, remain_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KeyBits-1:0]      rsp_key_ff;
   logic [OutBits-1:0]      rsp_payload_ff;
   logic                    rsp_last_ff;
   logic                    rsp_overflow_ff;

   logic                    full;
   logic                    wr_en;
   logic [WideBits-1:0]     wide_wr;
   logic [WideBits-1:0]     wide_rd;
   logic [KeyBits-1:0]      rd_key;
   logic [PAYLOAD_BITS-1:0] rd_payload;
   logic                    hit;
   logic                    cand;
   logic                    better;
   logic [KeyBits-1:0]      cand_key;
   logic                    found;
   logic                    out_free;
   logic                    emit;

   // Store write: append while there is room.
   assign full    = (count_ff == CountBits'(CAPACITY));
   assign wr_en   = cmd.load && !full;
   assign wide_wr = {{(WideBits - OutBits){1'b0}}, req_payload};

   skq_ram #(
      .WIDTH (KeyBits),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrBits-1:0]),
      .wr_data (req_key),
      .rd_addr (idx_ff),
      .rd_data (rd_key)
   );

   skq_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (CAPACITY)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrBits-1:0]),
      .wr_data (wide_wr[PAYLOAD_BITS-1:0]),
      .rd_addr (idx_ff),
      .rd_data (rd_payload)
   );

   assign wide_rd = WideBits'(rd_payload);

   // Key comparison on the entry read at the scan index. The first pass only
   // searches for the smallest key; later passes emit the current key and
   // search for the smallest key above it.
   assign hit      = !first_pass_ff && (rd_key == cur_key_ff);
   assign cand     = first_pass_ff || (rd_key > cur_key_ff);
   assign better   = cand && (!next_found_ff || (rd_key < next_key_ff));
   assign cand_key = better ? rd_key : next_key_ff;
   assign found    = next_found_ff || cand;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = cmd.eval && hit;

   assign status.hit      = hit;
   assign status.out_free = out_free;
   assign status.idx_last = ((CountBits'(idx_ff) + CountBits'(1)) == count_ff);
   assign status.found    = found;

   // Next values of the control registers.
   always_comb begin
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      idx_in        = idx_ff;
      cur_key_in    = cur_key_ff;
      next_key_in   = next_key_ff;
      next_found_in = next_found_ff;
      first_pass_in = first_pass_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff;

      // Loading: append the item, or note that it was dropped.
      if (cmd.load) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CountBits'(1);
         end
      end

      // Drain start: rewind the scan for the minimum search.
      if (cmd.start) begin
         idx_in        = '0;
         next_found_in = 1'b0;
         first_pass_in = 1'b1;
      end

      if (emit) begin
         remain_in = remain_ff - CountBits'(1);
      end

      // Scan stepping and pass changes.
      if (cmd.advance) begin
         idx_in        = idx_ff + AddrBits'(1);
         next_key_in   = cand_key;
         next_found_in = found;
      end
      if (cmd.next_pass) begin
         idx_in        = '0;
         cur_key_in    = cand_key;
         next_found_in = 1'b0;
         first_pass_in = 1'b0;
         if (first_pass_ff) begin
            remain_in = count_ff;
         end
      end
      if (cmd.finish) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end

      // Result register: loads on emit, empties on a completed transfer.
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         idx_ff        <= '0;
         next_found_ff <= 1'b0;
         first_pass_ff <= 1'b1;
         remain_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         idx_ff        <= idx_in;
         next_found_ff <= next_found_in;
         first_pass_ff <= first_pass_in;
         remain_ff     <= remain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Key registers and result payload.
   always_ff @(posedge clock) begin
      cur_key_ff  <= cur_key_in;
      next_key_ff <= next_key_in;
      if (emit) begin
         rsp_key_ff      <= rd_key;
         rsp_payload_ff  <= wide_rd[OutBits-1:0];
         rsp_last_ff     <= (remain_ff == CountBits'(1));
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key      = rsp_key_ff;
   assign rsp_payload  = rsp_payload_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

/* rtl/skq_checker.sv */
// ----------------------------------------------------------------------------
// skq_checker
// Port-level checks of the sort queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module skq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_item_last,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [skq_pkg::KEY_BITS-1:0]         rsp_out_key,
   input logic [skq_pkg::OUT_PAYLOAD_BITS-1:0] rsp_out_payload
);

   // No result is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_out_payload))
      else $error("stalled result changed");

   // The item that closes a set starts the drain, so loading stops.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_item_last |=> !req_ready)
      else $error("input still taken after the last item of a set");

   // An ordinary item keeps the block in its load phase.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_item_last |=> req_ready)
      else $error("loading stopped without a last item");

endmodule

bind stable_key_sort_queue_core skq_checker u_skq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_item_last   (req_chan.item_last),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_key     (rsp_chan.out_key),
   .rsp_out_payload (rsp_chan.out_payload)
);
